// ===== rtl/tcce_pkg.sv =====
package tcce_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int CELL_AW    = $clog2(CELL_COUNT);

    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int BYTE_W = 8;
    localparam int CELL_W = 2 * BYTE_W;

    localparam int TAB_STEP = 8;

    localparam logic [COL_W:0]   COL_LIM = (COL_W + 1)'(COLUMNS);
    localparam logic [ROW_W+1:0] ROW_LIM = (ROW_W + 2)'(ROWS);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

    localparam logic [CELL_AW-1:0] SCROLL_END = CELL_AW'(CELL_COUNT - COLUMNS);
    localparam logic [CELL_AW-1:0] LAST_CELL  = CELL_AW'(CELL_COUNT - 1);

    localparam logic [BYTE_W-1:0] BLANK_CODE = 8'h20;
    localparam logic [BYTE_W-1:0] RESET_ATTR = 8'h0F;
    localparam logic [BYTE_W-1:0] CH_BS      = 8'h08;
    localparam logic [BYTE_W-1:0] CH_TAB     = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF      = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR      = 8'h0D;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    typedef struct packed {
        logic               wr_en;
        logic [CELL_AW-1:0] wr_addr;
        logic [CELL_W-1:0]  wr_data;
        logic               rd_en;
        logic [CELL_AW-1:0] rd_addr;
    } t_mem_req;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             wr;
        logic             scroll;
    } t_step;

    function automatic logic [CELL_AW-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                     input logic [COL_W-1:0] col);
        logic [CELL_AW-1:0] base;
        base = CELL_AW'(row * COLUMNS);
        return base + CELL_AW'(col);
    endfunction

endpackage

// ===== rtl/text_console_cursor_engine_unit.sv =====
// Channel   | Direction | Handshake              | Payload
// input     | in        | i_in_valid/o_in_ready  | operation, char_code, read_col, read_row
// output    | out       | o_out_valid/i_out_ready| cursor_col, cursor_row, cell_char, cell_attr
// config    | in        | i_cfg_valid/o_cfg_ready| text_attribute
//
// An ordinary put, clear-free read or ignored code passes from acceptance through S_EXEC,
// S_RDWAIT for an in-range read, and S_DONE before the next input can be accepted.
// A scroll copies rows 1 to ROWS-1 up one row, one cell a cycle, then blanks the last row.
// A clear writes one blank cell a cycle over the whole screen.
// After reset a clearing pass fills the screen before input is taken.
// A waiting result does not block taking the next input, whose result then holds in S_DONE.
module text_console_cursor_engine_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_operation,
    input  logic [tcce_pkg::BYTE_W-1:0]   i_char_code,
    input  logic [tcce_pkg::COL_W-1:0]    i_read_col,
    input  logic [tcce_pkg::ROW_W-1:0]    i_read_row,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [tcce_pkg::COL_W-1:0]    o_cursor_col,
    output logic [tcce_pkg::ROW_W-1:0]    o_cursor_row,
    output logic [tcce_pkg::BYTE_W-1:0]   o_cell_char,
    output logic [tcce_pkg::BYTE_W-1:0]   o_cell_attr,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tcce_pkg::BYTE_W-1:0]   i_cfg_text_attribute
);
    import tcce_pkg::*;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_RDWAIT,
        S_SCROLL,
        S_FILL,
        S_DONE
    } t_state;

    t_state             r_state;
    logic [BYTE_W-1:0]  r_attr;
    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;
    logic [1:0]         r_op;
    logic [BYTE_W-1:0]  r_code;
    logic [COL_W-1:0]   r_rd_col;
    logic [ROW_W-1:0]   r_rd_row;
    logic [BYTE_W-1:0]  r_char_res;
    logic [BYTE_W-1:0]  r_attr_res;
    logic [CELL_AW-1:0] r_ptr;
    logic               r_copy_pend;
    logic [CELL_W-1:0]  r_fill_val;
    logic               r_out_valid;
    logic [COL_W-1:0]   r_o_col;
    logic [ROW_W-1:0]   r_o_row;
    logic [BYTE_W-1:0]  r_o_char;
    logic [BYTE_W-1:0]  r_o_attr;

    t_step              step;
    t_mem_req           mem_req;
    logic [CELL_W-1:0]  rd_data;
    logic               rd_in_range;
    logic               out_free;

    tcce_cursor_step u_step (
        .i_col  (r_col),
        .i_row  (r_row),
        .i_code (r_code),
        .o_step (step)
    );

    tcce_cell_mem u_mem (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    assign rd_in_range = ({1'b0, r_rd_col} < COL_LIM) && ({2'b00, r_rd_row} < ROW_LIM);
    assign out_free    = !r_out_valid || i_out_ready;

    always_comb begin
        mem_req = '0;
        case (r_state)
            S_INIT, S_FILL: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = r_ptr;
                mem_req.wr_data = r_fill_val;
            end
            S_EXEC: begin
                if (r_op == OP_PUT) begin
                    mem_req.wr_en   = step.wr;
                    mem_req.wr_addr = cell_addr(r_row, r_col);
                    mem_req.wr_data = {r_attr, r_code};
                end else if (r_op == OP_READ) begin
                    mem_req.rd_en   = rd_in_range;
                    mem_req.rd_addr = cell_addr(r_rd_row, r_rd_col);
                end
            end
            S_SCROLL: begin
                mem_req.wr_en   = r_copy_pend;
                mem_req.wr_addr = r_ptr - CELL_AW'(1);
                mem_req.wr_data = rd_data;
                mem_req.rd_en   = (r_ptr != SCROLL_END);
                mem_req.rd_addr = r_ptr + CELL_AW'(COLUMNS);
            end
            default: begin
                mem_req = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_attr      <= RESET_ATTR;
            r_col       <= '0;
            r_row       <= '0;
            r_ptr       <= '0;
            r_copy_pend <= 1'b0;
            r_fill_val  <= {RESET_ATTR, BLANK_CODE};
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_attr <= i_cfg_text_attribute;
            end
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_INIT: begin
                    r_ptr <= r_ptr + CELL_AW'(1);
                    if (r_ptr == LAST_CELL) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op       <= i_operation;
                        r_code     <= i_char_code;
                        r_rd_col   <= i_read_col;
                        r_rd_row   <= i_read_row;
                        r_char_res <= '0;
                        r_attr_res <= '0;
                        r_state    <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    case (r_op)
                        OP_PUT: begin
                            r_col <= step.col;
                            r_row <= step.row;
                            if (step.scroll) begin
                                r_ptr       <= '0;
                                r_copy_pend <= 1'b0;
                                r_state     <= S_SCROLL;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end
                        OP_CLEAR: begin
                            r_col      <= '0;
                            r_row      <= '0;
                            r_ptr      <= '0;
                            r_fill_val <= {r_attr, BLANK_CODE};
                            r_state    <= S_FILL;
                        end
                        OP_READ: begin
                            r_state <= rd_in_range ? S_RDWAIT : S_DONE;
                        end
                        default: begin
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_RDWAIT: begin
                    r_char_res <= rd_data[BYTE_W-1:0];
                    r_attr_res <= rd_data[CELL_W-1:BYTE_W];
                    r_state    <= S_DONE;
                end
                S_SCROLL: begin
                    if (r_ptr == SCROLL_END) begin
                        r_copy_pend <= 1'b0;
                        r_fill_val  <= {r_attr, BLANK_CODE};
                        r_state     <= S_FILL;
                    end else begin
                        r_ptr       <= r_ptr + CELL_AW'(1);
                        r_copy_pend <= 1'b1;
                    end
                end
                S_FILL: begin
                    r_ptr <= r_ptr + CELL_AW'(1);
                    if (r_ptr == LAST_CELL) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_o_col     <= r_col;
                        r_o_row     <= r_row;
                        r_o_char    <= r_char_res;
                        r_o_attr    <= r_attr_res;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = r_out_valid;
    assign o_cursor_col = r_o_col;
    assign o_cursor_row = r_o_row;
    assign o_cell_char  = r_o_char;
    assign o_cell_attr  = r_o_attr;

endmodule

// ===== rtl/tcce_cell_mem.sv =====
module tcce_cell_mem (
    input  logic                      i_clk,
    input  tcce_pkg::t_mem_req        i_req,
    output logic [tcce_pkg::CELL_W-1:0] o_rd_data
);
    import tcce_pkg::*;

    logic [CELL_W-1:0] r_cells [CELL_COUNT];

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_cells[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            o_rd_data <= r_cells[i_req.rd_addr];
        end
    end

endmodule

// ===== rtl/tcce_cursor_step.sv =====
module tcce_cursor_step (
    input  logic [tcce_pkg::COL_W-1:0]  i_col,
    input  logic [tcce_pkg::ROW_W-1:0]  i_row,
    input  logic [tcce_pkg::BYTE_W-1:0] i_code,
    output tcce_pkg::t_step             o_step
);
    import tcce_pkg::*;

    logic [COL_W:0]   col_ext;
    logic [COL_W:0]   col_next;
    logic [ROW_W+1:0] row_next;
    logic             line_inc;
    logic             wr;

    always_comb begin
        col_ext  = {1'b0, i_col};
        col_next = col_ext;
        line_inc = 1'b0;
        wr       = 1'b0;
        if (i_code == CH_BS) begin
            if (i_col != '0) begin
                col_next = col_ext - (COL_W + 1)'(1);
            end
        end else if (i_code == CH_TAB) begin
            col_next = (col_ext + (COL_W + 1)'(TAB_STEP)) & ~(COL_W + 1)'(TAB_STEP - 1);
        end else if (i_code == CH_CR) begin
            col_next = '0;
        end else if (i_code == CH_LF) begin
            col_next = '0;
            line_inc = 1'b1;
        end else if (i_code >= BLANK_CODE) begin
            wr       = 1'b1;
            col_next = col_ext + (COL_W + 1)'(1);
        end
        if (col_next >= COL_LIM) begin
            col_next = '0;
            line_inc = 1'b1;
        end
        row_next = {2'b00, i_row} + (ROW_W + 2)'(line_inc);

        o_step.col    = col_next[COL_W-1:0];
        o_step.wr     = wr;
        o_step.scroll = (row_next >= ROW_LIM);
        o_step.row    = o_step.scroll ? LAST_ROW : row_next[ROW_W-1:0];
    end

endmodule

// ===== rtl/tcce_checker.sv =====
module tcce_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [tcce_pkg::COL_W-1:0]    o_cursor_col,
    input logic [tcce_pkg::ROW_W-1:0]    o_cursor_row,
    input logic [tcce_pkg::BYTE_W-1:0]   o_cell_char,
    input logic [tcce_pkg::BYTE_W-1:0]   o_cell_attr
);
    import tcce_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && o_out_valid && !i_out_ready |=>
        o_out_valid && $stable(o_cursor_col) && $stable(o_cursor_row) &&
        $stable(o_cell_char) && $stable(o_cell_attr))
        else $error("Output transaction changed while stalled.");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ({1'b0, o_cursor_col} < COL_LIM))
        else $error("Cursor column beyond the last column.");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ({2'b00, o_cursor_row} < ROW_LIM))
        else $error("Cursor row beyond the last row.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("Input accepted again while a transaction is in progress.");

endmodule

bind text_console_cursor_engine_unit tcce_checker u_tcce_checker (.*);
